/* src/fpwg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Package for the fixed-point waveform generator.
// Holds sizes, register and shape codes, reciprocal constants and the sine table.
// No dependencies.
package fpwg_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int SCALE         = 1000;
    localparam int HALF_SCALE    = 500;
    localparam int TWO_PI_SCALED = 6283;

    // first divider: 51-bit numerator, 42 quotient bits
    localparam int NUM_W   = 51;
    localparam int DIV_Q   = 42;

    // modulo by 1000 or 6283: 42-bit magnitude folded as two 21-bit halves
    localparam int MAG_W   = 42;
    localparam int HALF_W  = 21;
    localparam int QH_W    = 12;
    localparam int XF_W    = 26;
    localparam int Q2_W    = 17;
    localparam int MH_SH   = 34;
    localparam int ML_SH   = 39;

    localparam logic [24:0] MH_SCALE  = 25'(((longint'(1) << MH_SH) + SCALE - 1) / SCALE);
    localparam logic [24:0] MH_TWO_PI =
        25'(((longint'(1) << MH_SH) + TWO_PI_SCALED - 1) / TWO_PI_SCALED);
    localparam logic [12:0] K_SCALE   = 13'((longint'(1) << HALF_W) % SCALE);
    localparam logic [12:0] K_TWO_PI  = 13'((longint'(1) << HALF_W) % TWO_PI_SCALED);
    localparam logic [29:0] ML_SCALE  = 30'(((longint'(1) << ML_SH) + SCALE - 1) / SCALE);
    localparam logic [29:0] ML_TWO_PI =
        30'(((longint'(1) << ML_SH) + TWO_PI_SCALED - 1) / TWO_PI_SCALED);

    // table index: remainder * entries / 6283
    localparam int IX_SH   = 26 + IDX_W;
    localparam int IX_M_W  = IX_SH - 12;
    localparam int IXP_W   = 13 + IX_M_W;
    localparam logic [IX_M_W-1:0] IX_M =
        IX_M_W'(((longint'(1) << IX_SH) + TWO_PI_SCALED - 1) / TWO_PI_SCALED);

    // final scaling: 31-bit magnitude / 1000, 21 quotient bits
    localparam int FIN_W   = 31;
    localparam int FQ_W    = 21;
    localparam int FIN_SH  = 41;
    localparam logic [31:0] FIN_M = 32'(((longint'(1) << FIN_SH) + SCALE - 1) / SCALE);

    // divider stages, then fold (6), index, table, product, scaling, output
    localparam int LAT = (1 + DIV_Q) + 11;

    localparam logic [2:0] REG_WAVEFORM  = 3'd0;
    localparam logic [2:0] REG_PERIOD    = 3'd1;
    localparam logic [2:0] REG_PHASE     = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE = 3'd3;
    localparam logic [2:0] REG_OFFSET    = 3'd4;

    localparam logic [1:0] WAVE_SAW    = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;

    localparam logic signed [23:0] OUT_MAX = 24'sd2097151;
    localparam logic signed [23:0] OUT_MIN = -24'sd2097152;

    typedef logic signed [10:0] sine_rom_t [TABLE_ENTRIES];

    localparam real PI       = 3.14159265358979323846;
    localparam real ROM_STEP = 2.0 * PI / real'(TABLE_ENTRIES);

    // round(1000*sin(2*pi*i/N)), halves away from zero
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        real       x;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            x = 1000.0 * $sin(ROM_STEP * real'(i));
            if (x >= 0.0)
            begin
                rom[i] = 11'($rtoi(x + 0.5));
            end
            else
            begin
                rom[i] = -11'($rtoi(0.5 - x));
            end
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

/* src/fixed_point_waveform_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Fixed-point waveform generator: sawtooth, square and sine, pipelined.
// Depends on fpwg_pkg.
//
// channel | dir | handshake              | payload
// s       | in  | s_tvalid / s_tready    | s_tdata[30:0] time_value
// m       | out | m_tvalid / m_tready    | m_tdata[21:0] sample
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while the output is not stalled.
// Latency is set by the bit-per-stage divider for the time scaling (43 stages,
// period is the divisor for square); modulo, table index and amplitude scaling
// use reciprocal multiplies over the remaining 11 stages.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module fixed_point_waveform_generator
    import fpwg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] time_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [21:0] sample
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [20:0] cfg_data
);

    logic [1:0]         waveform_reg;
    logic [19:0]        period_reg;
    logic signed [20:0] phase_reg;
    logic signed [20:0] amplitude_reg;
    logic signed [20:0] offset_reg;

    logic [LAT-1:0] vld_reg;
    logic           ce;
    logic           is_sq;
    logic           is_sine;

    assign is_sq   = (waveform_reg == WAVE_SQUARE);
    assign is_sine = (waveform_reg != WAVE_SQUARE) && (waveform_reg != WAVE_SAW);

    assign ce        = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = ce;
    assign m_tvalid  = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= WAVE_SAW;
            period_reg    <= 20'd1000;
            phase_reg     <= '0;
            amplitude_reg <= 21'sd1000;
            offset_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WAVEFORM:  waveform_reg  <= cfg_data[1:0];
                REG_PERIOD:    period_reg    <= cfg_data[19:0];
                REG_PHASE:     phase_reg     <= cfg_data;
                REG_AMPLITUDE: amplitude_reg <= cfg_data;
                REG_OFFSET:    offset_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // time scaling: t*period/1000, or t*1000/period for square
    logic [19:0]      mul_b;
    logic [19:0]      dvs;
    logic [NUM_W-1:0] num;
    logic [20:0]      dx;

    logic [19:0]      dr_reg  [0:DIV_Q];
    logic [19:0]      dr_next [0:DIV_Q];
    logic [DIV_Q-1:0] dl_reg  [0:DIV_Q];
    logic [DIV_Q-1:0] dl_next [0:DIV_Q];

    assign mul_b = is_sq ? 20'(SCALE) : period_reg;
    assign dvs   = !is_sq ? 20'(SCALE) : ((period_reg == '0) ? 20'd1 : period_reg);
    assign num   = NUM_W'(s_tdata[30:0]) * NUM_W'(mul_b);

    always_comb
    begin
        dx         = '0;
        dr_next[0] = 20'(num[NUM_W-1:DIV_Q]);
        dl_next[0] = num[DIV_Q-1:0];
        for (int k = 0; k < DIV_Q; k++)
        begin
            dx = {dr_reg[k], dl_reg[k][DIV_Q-1]};
            if (dx >= {1'b0, dvs})
            begin
                dr_next[k+1] = 20'(dx - {1'b0, dvs});
                dl_next[k+1] = {dl_reg[k][DIV_Q-2:0], 1'b1};
            end
            else
            begin
                dr_next[k+1] = dx[19:0];
                dl_next[k+1] = {dl_reg[k][DIV_Q-2:0], 1'b0};
            end
        end
    end

    // phase add, sign split, modulo by 1000 or 6283 in two 21-bit folds
    logic signed [43:0] pv;
    logic [12:0]        modc;
    logic [24:0]        mh_m;
    logic [12:0]        fold_k;
    logic [29:0]        ml_m;
    logic [45:0]        qh_prod;
    logic [24:0]        rh_full;
    logic [55:0]        q2_prod;
    logic [XF_W-1:0]    mr_full;

    logic [MAG_W-1:0]  mg_reg;
    logic              mgn_reg;
    logic [MAG_W-1:0]  ma_reg;
    logic [QH_W-1:0]   qh_reg;
    logic              an_reg;
    logic [12:0]       rh_reg;
    logic [HALF_W-1:0] al_reg;
    logic              bn_reg;
    logic [XF_W-1:0]   xf_reg;
    logic              cn_reg;
    logic [XF_W-1:0]   xd_reg;
    logic [Q2_W-1:0]   q2_reg;
    logic              dn_reg;
    logic [12:0]       mr_reg;
    logic              en_reg;

    assign pv      = $signed({2'b00, dl_reg[DIV_Q]}) + 44'(phase_reg);
    assign modc    = is_sine ? 13'(TWO_PI_SCALED) : 13'(SCALE);
    assign mh_m    = is_sine ? MH_TWO_PI : MH_SCALE;
    assign fold_k  = is_sine ? K_TWO_PI : K_SCALE;
    assign ml_m    = is_sine ? ML_TWO_PI : ML_SCALE;
    assign qh_prod = 46'(mg_reg[MAG_W-1:HALF_W]) * 46'(mh_m);
    assign rh_full = 25'(ma_reg[MAG_W-1:HALF_W]) - 25'(qh_reg) * 25'(modc);
    assign q2_prod = 56'(xf_reg) * 56'(ml_m);
    assign mr_full = xd_reg - XF_W'(q2_reg) * XF_W'(modc);

    // table index: remainder*entries/6283
    logic [IXP_W-1:0] ix_prod;
    logic [IDX_W-1:0] xi_reg;
    logic [12:0]      xm_reg;
    logic             xn_reg;
    logic             xh_reg;

    assign ix_prod = IXP_W'(mr_reg) * IXP_W'(IX_M);

    // operand select: table value or signed remainder
    logic [IDX_W-1:0]   qi;
    logic [IDX_W-1:0]   idx;
    logic signed [13:0] mv;
    logic signed [13:0] op_next;
    logic signed [13:0] op_reg;
    logic               oh_reg;

    assign qi  = xi_reg;
    assign idx = (xn_reg && (qi != '0))
               ? IDX_W'((IDX_W+1)'(TABLE_ENTRIES) - {1'b0, qi}) : qi;
    assign mv  = xn_reg ? -$signed({1'b0, xm_reg}) : $signed({1'b0, xm_reg});
    assign op_next = is_sine ? 14'(SINE_ROM[idx]) : mv;

    // amplitude product, then divide by 1000
    logic signed [34:0] prod;
    logic [FIN_W-1:0]   pmag;
    logic [62:0]        fq_prod;

    logic [FIN_W-1:0] pm_reg;
    logic             pn_reg;
    logic             ph_reg;
    logic [FQ_W-1:0]  fq_reg;
    logic             fn_reg;
    logic             fh_reg;

    assign prod    = 35'(op_reg) * 35'(amplitude_reg);
    assign pmag    = prod[34] ? FIN_W'(-prod) : prod[FIN_W-1:0];
    assign fq_prod = 63'(pm_reg) * 63'(FIN_M);

    // offset, square select, saturation
    logic signed [23:0] sv;
    logic signed [23:0] res;
    logic [21:0]        sample_next;
    logic [21:0]        sample_reg;

    assign sv = fn_reg ? -$signed({3'b000, fq_reg}) : $signed({3'b000, fq_reg});

    always_comb
    begin
        if (is_sq)
        begin
            res = fh_reg ? 24'(amplitude_reg) + 24'(offset_reg) : 24'(offset_reg);
        end
        else
        begin
            res = sv + 24'(offset_reg);
        end
        if (res > OUT_MAX)
        begin
            sample_next = OUT_MAX[21:0];
        end
        else if (res < OUT_MIN)
        begin
            sample_next = OUT_MIN[21:0];
        end
        else
        begin
            sample_next = res[21:0];
        end
    end

    assign m_tdata = {2'b00, sample_reg};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k <= DIV_Q; k++)
            begin
                dr_reg[k] <= dr_next[k];
                dl_reg[k] <= dl_next[k];
            end
            mg_reg     <= pv[43] ? MAG_W'(-pv) : pv[MAG_W-1:0];
            mgn_reg    <= pv[43];
            ma_reg     <= mg_reg;
            qh_reg     <= qh_prod[MH_SH +: QH_W];
            an_reg     <= mgn_reg;
            rh_reg     <= rh_full[12:0];
            al_reg     <= ma_reg[HALF_W-1:0];
            bn_reg     <= an_reg;
            xf_reg     <= XF_W'(rh_reg) * XF_W'(fold_k) + XF_W'(al_reg);
            cn_reg     <= bn_reg;
            xd_reg     <= xf_reg;
            q2_reg     <= q2_prod[ML_SH +: Q2_W];
            dn_reg     <= cn_reg;
            mr_reg     <= mr_full[12:0];
            en_reg     <= dn_reg;
            xi_reg     <= ix_prod[IX_SH-IDX_W +: IDX_W];
            xm_reg     <= mr_reg;
            xn_reg     <= en_reg;
            xh_reg     <= !en_reg && (mr_reg >= 13'(HALF_SCALE));
            op_reg     <= op_next;
            oh_reg     <= xh_reg;
            pm_reg     <= pmag;
            pn_reg     <= prod[34];
            ph_reg     <= oh_reg;
            fq_reg     <= fq_prod[FIN_SH +: FQ_W];
            fn_reg     <= pn_reg;
            fh_reg     <= ph_reg;
            sample_reg <= sample_next;
        end
    end

endmodule
`default_nettype wire

/* tb/sv/tb_fixed_point_waveform_generator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fixed_point_waveform_generator: streams time values
// with random gaps and stalls, predicts every sample in 64-bit arithmetic.
// Depends on fpwg_pkg and the generator RTL.
module tb_fixed_point_waveform_generator;
    import fpwg_pkg::*;

    localparam logic [1:0] WAVE_SINE  = 2'd2;
    localparam logic [1:0] WAVE_SPARE = 2'd3;
    localparam logic [2:0] REG_BEYOND = 3'd5;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int         DRAIN      = 140;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_data;

    fixed_point_waveform_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [1:0]         shape;
    logic [19:0]        rate;
    logic signed [20:0] phase_ofs;
    logic signed [20:0] amp;
    logic signed [20:0] dc_ofs;

    int                 sine_table [TABLE_ENTRIES];
    logic [21:0]        pending_samples [$];
    int                 errors;
    bit                 idle_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [21:0] sample_of(input logic [30:0] t_in);
        longint t;
        longint p;
        longint v;
        longint res;
        longint idx;
        t = longint'(t_in);
        p = longint'(rate);
        if (shape == WAVE_SAW)
        begin
            v   = (t * p / 1000 + longint'(phase_ofs)) % 1000;
            res = v * longint'(amp) / 1000 + longint'(dc_ofs);
        end
        else if (shape == WAVE_SQUARE)
        begin
            if (p == 0)
            begin
                p = 1;
            end
            v   = t * 1000 / p + longint'(phase_ofs);
            res = (v % 1000 >= 500) ? longint'(amp) + longint'(dc_ofs) : longint'(dc_ofs);
        end
        else
        begin
            v   = (t * p / 1000 + longint'(phase_ofs)) % 6283;
            idx = v * TABLE_ENTRIES / 6283;
            if (idx < 0)
            begin
                idx += TABLE_ENTRIES;
            end
            res = longint'(sine_table[idx]) * longint'(amp) / 1000 + longint'(dc_ofs);
        end
        if (res > 2097151)
        begin
            res = 2097151;
        end
        if (res < -2097152)
        begin
            res = -2097152;
        end
        return res[21:0];
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        logic [21:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample %h", m_tdata[21:0]));
            end
            else
            begin
                want = pending_samples.pop_front();
                if (m_tdata[21:0] !== want)
                begin
                    report_mismatch($sformatf("sample got %h want %h", m_tdata[21:0], want));
                end
            end
        end
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (idle_on)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic send_time(input logic [30:0] t);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, t};
        do @(posedge clk); while (!s_tready);
        pending_samples.push_back(sample_of(t));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [20:0] value);
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WAVEFORM:  shape     = value[1:0];
            REG_PERIOD:    rate      = value[19:0];
            REG_PHASE:     phase_ofs = value;
            REG_AMPLITUDE: amp       = value;
            REG_OFFSET:    dc_ofs    = value;
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [1:0] w, input logic [19:0] p,
                           input logic [20:0] ph, input logic [20:0] a, input logic [20:0] o);
        write_reg(REG_WAVEFORM, {19'd0, w});
        write_reg(REG_PERIOD, {1'b0, p});
        write_reg(REG_PHASE, ph);
        write_reg(REG_AMPLITUDE, a);
        write_reg(REG_OFFSET, o);
    endtask

    task automatic send_edges();
        send_time(31'd0);
        send_time(31'd1);
        send_time(31'd499);
        send_time(31'd500);
        send_time(31'd999);
        send_time(31'h7FFF_FFFF);
        send_time(31'h4000_0000);
        send_time(31'($urandom));
    endtask

    task automatic test_defaults();
        send_edges();
    endtask

    task automatic test_shapes();
        set_all(WAVE_SQUARE, 20'd1000, 21'd0, 21'd1000, 21'd0);
        send_edges();
        set_all(WAVE_SINE, 20'd1000, 21'd0, 21'd1000, 21'd0);
        for (int i = 0; i < 8; i++)
        begin
            send_time(31'(i * 785));
        end
        write_reg(REG_WAVEFORM, {19'd0, WAVE_SPARE});
        send_edges();
    endtask

    task automatic test_extremes();
        set_all(WAVE_SQUARE, 20'd0, 21'h10_0000, 21'h0F_FFFF, 21'h0F_FFFF);
        send_edges();
        set_all(WAVE_SAW, 20'hF_FFFF, 21'h10_0000, 21'h10_0000, 21'h10_0000);
        send_edges();
        set_all(WAVE_SINE, 20'hF_FFFF, 21'h0F_FFFF, 21'h10_0000, 21'h0F_FFFF);
        send_edges();
        set_all(WAVE_SINE, 20'd1, -21'sd5000, 21'h0F_FFFF, 21'h10_0000);
        send_edges();
        write_reg(REG_UNUSED, 21'h1F_FFFF);
        write_reg(REG_BEYOND, 21'd0);
        send_edges();
    endtask

    task automatic test_random();
        logic [20:0] v [5];
        for (int ph = 0; ph < 16; ph++)
        begin
            if (ph == 13)
            begin
                idle_on = 1'b0;
            end
            for (int r = 0; r < 5; r++)
            begin
                case ($urandom_range(0, 5))
                    0:       v[r] = 21'h10_0000;
                    1:       v[r] = 21'h0F_FFFF;
                    2:       v[r] = 21'($urandom_range(0, 2000));
                    default: v[r] = 21'($urandom);
                endcase
            end
            set_all(v[0][1:0], v[1][19:0], v[2], v[3], v[4]);
            for (int i = 0; i < 56; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_time(31'($urandom));
                end
                else
                begin
                    send_time(31'($urandom_range(0, 20000)));
                end
            end
        end
    endtask

    initial
    begin
        real x;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            x = 1000.0 * $sin(2.0 * 3.14159265358979323846 * i / TABLE_ENTRIES);
            sine_table[i] = (x >= 0.0) ? $rtoi(x + 0.5) : -$rtoi(0.5 - x);
        end
        errors    = 0;
        idle_on   = 1'b1;
        shape     = WAVE_SAW;
        rate      = 20'd1000;
        phase_ofs = 21'sd0;
        amp       = 21'sd1000;
        dc_ofs    = 21'sd0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_WAVEFORM;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_shapes();
        test_extremes();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
